// ===== src/tapvc_pkg.sv =====
package tapvc_pkg;

  localparam int ACCUM_WIDTH = 48;

  localparam int POS_W     = 32;
  localparam int ROT_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = POS_W + 1;
  localparam int DIFF_W    = POS_W + 2;
  localparam int LIMIT_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int LO_W      = 32;
  localparam int HI_W      = ACCUM_WIDTH - LO_W;
  localparam int LO_P_W    = LO_W + GAIN_W;
  localparam int HI_P_W    = HI_W + GAIN_W;
  localparam int PROD_W    = ACCUM_WIDTH + GAIN_W;
  localparam int FRAC_GAIN = 12;
  localparam int MAG_W     = 51;
  localparam int PSUM_W    = (PROD_W + 1 > MAG_W + FRAC_GAIN) ? PROD_W + 1 : MAG_W + FRAC_GAIN;
  localparam int RND_W     = PSUM_W - FRAC_GAIN;
  localparam int TERM_W    = MAG_W + 2;
  localparam int VW_W      = 40;

  localparam int MUL_A_W   = VW_W + 1;
  localparam int MUL_B_W   = 25;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  localparam int SQ_W      = 48;
  localparam int DIST_W    = SQ_W + 2;
  localparam int FRAC_ROT  = 14;
  localparam int ROT_SUM_W = VW_W + ROT_W + 1;
  localparam int Q_W       = ROT_SUM_W - FRAC_ROT;

  localparam logic [PSUM_W-1:0]       ROUND_GAIN = PSUM_W'(2048);
  localparam logic [ROT_SUM_W-1:0]    ROUND_ROT  = ROT_SUM_W'(8192);
  localparam logic [MAG_W-1:0]        TERM_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic signed [ERR_W-1:0] NEAR_LIMIT = ERR_W'(33'sd16777216);

  localparam logic signed [POS_W-1:0] GOAL_X_RST = '0;
  localparam logic signed [POS_W-1:0] GOAL_Y_RST = '0;
  localparam logic signed [POS_W-1:0] GOAL_Z_RST = POS_W'(98304);
  localparam logic [GAIN_W-1:0]       KP_XY_RST  = GAIN_W'(410);
  localparam logic [GAIN_W-1:0]       KP_Z_RST   = GAIN_W'(1229);
  localparam logic [GAIN_W-1:0]       KI_RST     = '0;
  localparam logic [GAIN_W-1:0]       KD_RST     = GAIN_W'(2048);
  localparam logic [LIMIT_W-1:0]      REACH_RST  = LIMIT_W'(655);

  localparam logic [1:0] AXIS_LAST = 2'd2;
  localparam logic [2:0] MUL_LAST  = 3'd6;
  localparam logic [2:0] TAIL_LAST = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_X,
    REG_GOAL_Y,
    REG_GOAL_Z,
    REG_KP_XY,
    REG_KP_Z,
    REG_KI_ALL,
    REG_KD_ALL,
    REG_REACH_LIMIT_SQ
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_PLO,
    OP_PHI,
    OP_ILO,
    OP_IHI,
    OP_DLO,
    OP_DHI,
    OP_SQ,
    OP_VW,
    OP_ROT,
    OP_PUB
  } dp_op_t;

  typedef enum logic [2:0] {
    MT_NONE,
    MT_LO,
    MT_HI,
    MT_SQ,
    MT_ROT
  } mul_tag_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_MUL,
    S_WAIT,
    S_VW,
    S_ROT,
    S_TAIL,
    S_PUB
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic [1:0] col;
    logic       first;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [ROT_W-1:0] rot_00;
    logic signed [ROT_W-1:0] rot_01;
    logic signed [ROT_W-1:0] rot_02;
    logic signed [ROT_W-1:0] rot_10;
    logic signed [ROT_W-1:0] rot_11;
    logic signed [ROT_W-1:0] rot_12;
    logic signed [ROT_W-1:0] rot_20;
    logic signed [ROT_W-1:0] rot_21;
    logic signed [ROT_W-1:0] rot_22;
  } pose_t;

  typedef struct packed {
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic signed [POS_W-1:0] vel_z;
    logic                    at_goal;
  } vel_t;

endpackage

// ===== src/tapvc_pose_if.sv =====
interface tapvc_pose_if;
  import tapvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [ROT_W-1:0] rot_00;
  logic signed [ROT_W-1:0] rot_01;
  logic signed [ROT_W-1:0] rot_02;
  logic signed [ROT_W-1:0] rot_10;
  logic signed [ROT_W-1:0] rot_11;
  logic signed [ROT_W-1:0] rot_12;
  logic signed [ROT_W-1:0] rot_20;
  logic signed [ROT_W-1:0] rot_21;
  logic signed [ROT_W-1:0] rot_22;

  modport source (
    output valid, pos_x, pos_y, pos_z,
    output rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z,
    input  rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    output ready
  );
endinterface

// ===== src/tapvc_vel_if.sv =====
interface tapvc_vel_if;
  import tapvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] vel_x;
  logic signed [POS_W-1:0] vel_y;
  logic signed [POS_W-1:0] vel_z;
  logic                    at_goal;

  modport source (output valid, vel_x, vel_y, vel_z, at_goal, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, at_goal, output ready);
endinterface

// ===== src/tapvc_cfg_if.sv =====
interface tapvc_cfg_if;
  import tapvc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/three_axis_pid_velocity_command.sv =====
// Three-axis PID velocity command.
// pose (sink): one request per pose sample, position Q16.16 and the
//   robot-to-world rotation Q2.14. Accepted when valid and ready are high.
// vel (source): one request per pose sample, robot-frame velocity Q16.16
//   saturated to 32 bits, plus the goal-reached flag.
// cfg (sink): register writes by index, always ready; write only while idle.
// A new pose request is taken only once the previous result has moved to the output register.
// One shared 41x25 multiplier does all 30 products (two partial products per
//   gain term, one square per axis, nine rotation products); the sequencer
//   issues one per cycle while in its multiply and rotation states.
// The result waits in an output register; the next pose is taken while it
//   waits. If vel is stalled when the next result is done, the block holds
//   that result internally until the register is free.
// Reset: synchronous rst restores the register defaults, clears the error
//   sums and previous errors, and empties the output register.
module three_axis_pid_velocity_command (
  input  logic          clk,
  input  logic          rst,
  tapvc_pose_if.sink    pose,
  tapvc_vel_if.source   vel,
  tapvc_cfg_if.sink     cfg
);
  import tapvc_pkg::*;

  dp_cmd_t cmd;
  pose_t   pose_data;
  vel_t    vel_data;
  logic    in_ready;
  logic    out_valid;

  assign pose_data.pos_x  = pose.pos_x;
  assign pose_data.pos_y  = pose.pos_y;
  assign pose_data.pos_z  = pose.pos_z;
  assign pose_data.rot_00 = pose.rot_00;
  assign pose_data.rot_01 = pose.rot_01;
  assign pose_data.rot_02 = pose.rot_02;
  assign pose_data.rot_10 = pose.rot_10;
  assign pose_data.rot_11 = pose.rot_11;
  assign pose_data.rot_12 = pose.rot_12;
  assign pose_data.rot_20 = pose.rot_20;
  assign pose_data.rot_21 = pose.rot_21;
  assign pose_data.rot_22 = pose.rot_22;

  assign pose.ready       = in_ready;
  assign cfg.ready        = 1'b1;
  assign vel.valid        = out_valid;
  assign vel.vel_x        = vel_data.vel_x;
  assign vel.vel_y        = vel_data.vel_y;
  assign vel.vel_z        = vel_data.vel_z;
  assign vel.at_goal      = vel_data.at_goal;

  tapvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pose.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (vel.ready),
    .cmd       (cmd)
  );

  tapvc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pose_in   (pose_data),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .vel_out   (vel_data)
  );

endmodule

// ===== src/tapvc_ctrl.sv =====
module tapvc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output tapvc_pkg::dp_cmd_t cmd
);
  import tapvc_pkg::*;

  ctrl_state_t state, state_next;
  logic [2:0]  cnt, cnt_next;
  logic [1:0]  axis, axis_next;
  logic [1:0]  col, col_next;
  logic        out_valid_next;
  logic        pub_go;

  assign pub_go = (state == S_PUB) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    axis_next  = axis;
    col_next   = col;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_ERR;
          axis_next  = '0;
        end
      end
      S_ERR: begin
        state_next = S_MUL;
        cnt_next   = '0;
      end
      S_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = S_WAIT;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      S_WAIT: state_next = S_VW;
      S_VW: begin
        if (axis == AXIS_LAST) begin
          state_next = S_ROT;
          axis_next  = '0;
          col_next   = '0;
        end else begin
          state_next = S_ERR;
          axis_next  = axis + 2'd1;
        end
      end
      S_ROT: begin
        if (axis == AXIS_LAST) begin
          axis_next = '0;
          if (col == AXIS_LAST) begin
            state_next = S_TAIL;
            cnt_next   = '0;
          end else begin
            col_next = col + 2'd1;
          end
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      S_TAIL: begin
        if (cnt == TAIL_LAST) begin
          state_next = S_PUB;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      S_PUB: begin
        if (pub_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (pub_go) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    cmd.op    = OP_NONE;
    cmd.axis  = axis;
    cmd.col   = col;
    cmd.first = (axis == '0);
    cmd.last  = (axis == AXIS_LAST);
    case (state)
      S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_ERR:  cmd.op = OP_ERR;
      S_MUL: begin
        case (cnt)
          3'd0:    cmd.op = OP_PLO;
          3'd1:    cmd.op = OP_PHI;
          3'd2:    cmd.op = OP_ILO;
          3'd3:    cmd.op = OP_IHI;
          3'd4:    cmd.op = OP_DLO;
          3'd5:    cmd.op = OP_DHI;
          default: cmd.op = OP_SQ;
        endcase
      end
      S_VW:   cmd.op = OP_VW;
      S_ROT:  cmd.op = OP_ROT;
      S_PUB:  cmd.op = pub_go ? OP_PUB : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      axis      <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      axis      <= axis_next;
      col       <= col_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== src/tapvc_datapath.sv =====
module tapvc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tapvc_pkg::dp_cmd_t                  cmd,
  input  tapvc_pkg::pose_t                    pose_in,
  input  logic                                cfg_we,
  input  logic [tapvc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tapvc_pkg::CFG_DAT_W-1:0]     cfg_data,
  output tapvc_pkg::vel_t                     vel_out
);
  import tapvc_pkg::*;

  localparam int AW = ACCUM_WIDTH;

  logic signed [POS_W-1:0]   goal [3];
  logic [GAIN_W-1:0]         kp_xy, kp_z, ki_all, kd_all;
  logic [LIMIT_W-1:0]        reach_limit_sq;

  logic signed [AW-1:0]      error_accum [3];
  logic signed [ERR_W-1:0]   last_error [3];

  pose_t                     pose_r;
  logic signed [ERR_W-1:0]   e_cur;
  logic signed [AW-1:0]      a_cur;
  logic signed [DIFF_W-1:0]  d_cur;
  logic                      near_cur;
  logic                      far;

  logic signed [MUL_P_W-1:0] mul_p;
  mul_tag_t                  tag;
  logic                      tag_neg, tag_near, tag_first, tag_last;
  logic [1:0]                tag_col;

  logic [LO_P_W-1:0]         prod_lo;
  logic [MAG_W-1:0]          mag_r;
  logic                      mag_neg, mag_vld;
  logic signed [TERM_W-1:0]  t_acc;
  logic [DIST_W-1:0]         dist_sum;
  logic signed [VW_W-1:0]    vw [3];
  logic signed [ROT_SUM_W-1:0] rsum;
  logic                      fin_vld;
  logic [1:0]                fin_col;
  logic signed [POS_W-1:0]   vel_w [3];

  logic signed [POS_W-1:0]   goal_sel, pos_sel;
  logic signed [AW-1:0]      acc_sel;
  logic signed [ERR_W-1:0]   last_sel;
  logic signed [ERR_W-1:0]   e_new;
  logic signed [AW:0]        a_sum;
  logic signed [AW-1:0]      a_sat;
  logic signed [DIFF_W-1:0]  d_new;
  logic                      near_new;

  logic signed [AW-1:0]      term_x;
  logic                      term_neg;
  logic [AW-1:0]             term_mag;
  logic [GAIN_W-1:0]         gain_sel;
  logic signed [ROT_W-1:0]   rot_sel;
  logic signed [VW_W-1:0]    vw_sel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  mul_tag_t                  tag_next;

  logic [PSUM_W-1:0]         psum;
  logic [RND_W-1:0]          rnd;
  logic [MAG_W-1:0]          mag_clip;
  logic signed [TERM_W-1:0]  t_term;
  logic signed [VW_W-1:0]    vw_sat;
  logic signed [ROT_SUM_W-1:0] rround;
  logic signed [Q_W-1:0]     q;
  logic signed [POS_W-1:0]   q_sat;

  always_comb begin
    case (cmd.axis)
      2'd0: begin
        goal_sel = goal[0];
        pos_sel  = pose_r.pos_x;
        acc_sel  = error_accum[0];
        last_sel = last_error[0];
        vw_sel   = vw[0];
      end
      2'd1: begin
        goal_sel = goal[1];
        pos_sel  = pose_r.pos_y;
        acc_sel  = error_accum[1];
        last_sel = last_error[1];
        vw_sel   = vw[1];
      end
      default: begin
        goal_sel = goal[2];
        pos_sel  = pose_r.pos_z;
        acc_sel  = error_accum[2];
        last_sel = last_error[2];
        vw_sel   = vw[2];
      end
    endcase
  end

  always_comb begin
    e_new    = ERR_W'(goal_sel) - ERR_W'(pos_sel);
    a_sum    = (AW + 1)'(acc_sel) + (AW + 1)'(e_new);
    if (a_sum[AW] != a_sum[AW-1]) begin
      a_sat = a_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      a_sat = a_sum[AW-1:0];
    end
    d_new    = DIFF_W'(e_new) - DIFF_W'(last_sel);
    near_new = (e_new < NEAR_LIMIT) && (e_new > -NEAR_LIMIT);
  end

  always_comb begin
    case (cmd.op)
      OP_PLO, OP_PHI: begin
        term_x   = AW'(e_cur);
        gain_sel = (cmd.axis == AXIS_LAST) ? kp_z : kp_xy;
      end
      OP_ILO, OP_IHI: begin
        term_x   = a_cur;
        gain_sel = ki_all;
      end
      OP_DLO, OP_DHI: begin
        term_x   = AW'(d_cur);
        gain_sel = kd_all;
      end
      default: begin
        term_x   = '0;
        gain_sel = '0;
      end
    endcase
    term_neg = term_x[AW-1];
    term_mag = term_neg ? (~term_x + 1'b1) : term_x;
  end

  always_comb begin
    case ({cmd.axis, cmd.col})
      4'b0000: rot_sel = pose_r.rot_00;
      4'b0001: rot_sel = pose_r.rot_01;
      4'b0010: rot_sel = pose_r.rot_02;
      4'b0100: rot_sel = pose_r.rot_10;
      4'b0101: rot_sel = pose_r.rot_11;
      4'b0110: rot_sel = pose_r.rot_12;
      4'b1000: rot_sel = pose_r.rot_20;
      4'b1001: rot_sel = pose_r.rot_21;
      4'b1010: rot_sel = pose_r.rot_22;
      default: rot_sel = '0;
    endcase
  end

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    tag_next = MT_NONE;
    case (cmd.op)
      OP_PLO, OP_ILO, OP_DLO: begin
        mul_a    = {{(MUL_A_W-LO_W){1'b0}}, term_mag[LO_W-1:0]};
        mul_b    = {{(MUL_B_W-GAIN_W){1'b0}}, gain_sel};
        tag_next = MT_LO;
      end
      OP_PHI, OP_IHI, OP_DHI: begin
        mul_a    = {{(MUL_A_W-HI_W){1'b0}}, term_mag[AW-1:LO_W]};
        mul_b    = {{(MUL_B_W-GAIN_W){1'b0}}, gain_sel};
        tag_next = MT_HI;
      end
      OP_SQ: begin
        mul_a    = MUL_A_W'(e_cur);
        mul_b    = e_cur[MUL_B_W-1:0];
        tag_next = MT_SQ;
      end
      OP_ROT: begin
        mul_a    = MUL_A_W'(vw_sel);
        mul_b    = MUL_B_W'(rot_sel);
        tag_next = MT_ROT;
      end
      default: tag_next = MT_NONE;
    endcase
  end

  always_comb begin
    psum     = PSUM_W'(prod_lo) + (PSUM_W'(mul_p[HI_P_W-1:0]) << LO_W) + ROUND_GAIN;
    rnd      = psum[PSUM_W-1:FRAC_GAIN];
    mag_clip = (rnd > RND_W'(TERM_LIMIT)) ? TERM_LIMIT : rnd[MAG_W-1:0];
    t_term   = mag_neg ? -$signed(TERM_W'(mag_r)) : $signed(TERM_W'(mag_r));
    if (t_acc[TERM_W-1:VW_W-1] != {(TERM_W-VW_W+1){t_acc[TERM_W-1]}}) begin
      vw_sat = t_acc[TERM_W-1] ? {1'b1, {(VW_W-1){1'b0}}} : {1'b0, {(VW_W-1){1'b1}}};
    end else begin
      vw_sat = t_acc[VW_W-1:0];
    end
    rround   = rsum + ROUND_ROT;
    q        = rround[ROT_SUM_W-1:FRAC_ROT];
    if (q[Q_W-1:POS_W-1] != {(Q_W-POS_W+1){q[Q_W-1]}}) begin
      q_sat = q[Q_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      q_sat = q[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal[0]        <= GOAL_X_RST;
      goal[1]        <= GOAL_Y_RST;
      goal[2]        <= GOAL_Z_RST;
      kp_xy          <= KP_XY_RST;
      kp_z           <= KP_Z_RST;
      ki_all         <= KI_RST;
      kd_all         <= KD_RST;
      reach_limit_sq <= REACH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GOAL_X:         goal[0]        <= cfg_data[POS_W-1:0];
        REG_GOAL_Y:         goal[1]        <= cfg_data[POS_W-1:0];
        REG_GOAL_Z:         goal[2]        <= cfg_data[POS_W-1:0];
        REG_KP_XY:          kp_xy          <= cfg_data[GAIN_W-1:0];
        REG_KP_Z:           kp_z           <= cfg_data[GAIN_W-1:0];
        REG_KI_ALL:         ki_all         <= cfg_data[GAIN_W-1:0];
        REG_KD_ALL:         kd_all         <= cfg_data[GAIN_W-1:0];
        REG_REACH_LIMIT_SQ: reach_limit_sq <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_accum[0] <= '0;
      error_accum[1] <= '0;
      error_accum[2] <= '0;
      last_error[0]  <= '0;
      last_error[1]  <= '0;
      last_error[2]  <= '0;
      tag            <= MT_NONE;
      mag_vld        <= 1'b0;
      fin_vld        <= 1'b0;
    end else begin
      tag     <= tag_next;
      mag_vld <= (tag == MT_HI);
      fin_vld <= (tag == MT_ROT) && tag_last;
      if (cmd.op == OP_ERR) begin
        case (cmd.axis)
          2'd0: begin
            error_accum[0] <= a_sat;
            last_error[0]  <= e_new;
          end
          2'd1: begin
            error_accum[1] <= a_sat;
            last_error[1]  <= e_new;
          end
          default: begin
            error_accum[2] <= a_sat;
            last_error[2]  <= e_new;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p     <= mul_a * mul_b;
    tag_neg   <= term_neg;
    tag_near  <= near_cur;
    tag_first <= cmd.first;
    tag_last  <= cmd.last;
    tag_col   <= cmd.col;
    fin_col   <= tag_col;

    case (cmd.op)
      OP_LOAD: begin
        pose_r   <= pose_in;
        far      <= 1'b0;
        dist_sum <= '0;
      end
      OP_ERR: begin
        e_cur    <= e_new;
        a_cur    <= a_sat;
        d_cur    <= d_new;
        near_cur <= near_new;
        far      <= far | !near_new;
      end
      OP_VW: begin
        case (cmd.axis)
          2'd0:    vw[0] <= vw_sat;
          2'd1:    vw[1] <= vw_sat;
          default: vw[2] <= vw_sat;
        endcase
      end
      OP_PUB: begin
        vel_out.vel_x   <= vel_w[0];
        vel_out.vel_y   <= vel_w[1];
        vel_out.vel_z   <= vel_w[2];
        vel_out.at_goal <= !far && (dist_sum < DIST_W'({reach_limit_sq, 16'b0}));
      end
      default: ;
    endcase

    if (cmd.op == OP_LOAD || cmd.op == OP_VW) begin
      t_acc <= '0;
    end else if (mag_vld) begin
      t_acc <= t_acc + t_term;
    end

    case (tag)
      MT_LO: prod_lo <= mul_p[LO_P_W-1:0];
      MT_HI: begin
        mag_r   <= mag_clip;
        mag_neg <= tag_neg;
      end
      MT_SQ: begin
        if (tag_near) begin
          dist_sum <= dist_sum + DIST_W'(mul_p[SQ_W-1:0]);
        end
      end
      MT_ROT: rsum <= (tag_first ? '0 : rsum) + mul_p[ROT_SUM_W-1:0];
      default: ;
    endcase

    if (fin_vld) begin
      case (fin_col)
        2'd0:    vel_w[0] <= q_sat;
        2'd1:    vel_w[1] <= q_sat;
        default: vel_w[2] <= q_sat;
      endcase
    end
  end

endmodule

// ===== sim/three_axis_pid_velocity_command_tb.sv =====
module three_axis_pid_velocity_command_tb;
  import tapvc_pkg::*;

  localparam logic signed [POS_W-1:0] POS_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN   = 32'sh80000000;
  localparam logic signed [POS_W-1:0] FAR_EDGE  = 32'sd16777216;
  localparam logic signed [ROT_W-1:0] UNIT      = 16'sd16384;
  localparam logic signed [ROT_W-1:0] ROT_CODE_MAX = 16'sh7FFF;
  localparam logic signed [ROT_W-1:0] ROT_CODE_MIN = 16'sh8000;
  localparam longint unsigned TERM_CAP = 64'd1 << 50;
  localparam longint VW_HI  = (longint'(1) <<< 39) - 1;
  localparam longint VW_LO  = -(longint'(1) <<< 39);
  localparam longint VEL_HI = 64'sd2147483647;
  localparam longint VEL_LO = -64'sd2147483648;

  logic clk;
  logic rst;

  tapvc_pose_if pose ();
  tapvc_vel_if  vel ();
  tapvc_cfg_if  cfg ();

  three_axis_pid_velocity_command i_dut (
    .clk  (clk),
    .rst  (rst),
    .pose (pose),
    .vel  (vel),
    .cfg  (cfg)
  );

  logic signed [POS_W-1:0] goal_cfg [3];
  logic [GAIN_W-1:0]       kp_xy_cfg;
  logic [GAIN_W-1:0]       kp_z_cfg;
  logic [GAIN_W-1:0]       ki_cfg;
  logic [GAIN_W-1:0]       kd_cfg;
  logic [LIMIT_W-1:0]      reach_sq_cfg;
  longint                  err_sum [3];
  longint                  prev_err [3];

  pose_t pending_poses [$];
  vel_t  expected_cmds [$];
  pose_t sent_pose;

  int send_idle_pct;
  int recv_stall_pct;
  int poses_taken;
  int results_seen;
  int reached_count;
  int settings_count;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("three_axis_pid_velocity_command_tb NOT OK");
    $finish;
  end

  function automatic longint gain_term(longint x, logic [GAIN_W-1:0] g);
    longint unsigned mag;
    longint unsigned r;
    mag = (x < 0) ? -x : x;
    r = (mag * g + 64'd2048) >> 12;
    if (r > TERM_CAP) r = TERM_CAP;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic vel_t predict_velocity_command(pose_t p);
    longint amax;
    longint amin;
    longint pos [3];
    longint vw [3];
    longint err;
    longint acc;
    longint diff;
    longint t;
    longint s;
    longint q;
    longint unsigned dist_sq;
    logic far;
    logic [GAIN_W-1:0] kp;
    logic signed [ROT_W-1:0] rot [9];
    logic signed [POS_W-1:0] out_vel [3];
    vel_t cmd;
    amax = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
    amin = -amax - 1;
    dist_sq = 0;
    far = 1'b0;
    pos[0] = p.pos_x;
    pos[1] = p.pos_y;
    pos[2] = p.pos_z;
    {rot[0], rot[1], rot[2], rot[3], rot[4], rot[5], rot[6], rot[7], rot[8]} =
      {p.rot_00, p.rot_01, p.rot_02, p.rot_10, p.rot_11, p.rot_12,
       p.rot_20, p.rot_21, p.rot_22};
    for (int i = 0; i < 3; i++) begin
      err = longint'(goal_cfg[i]) - pos[i];
      acc = err_sum[i];
      if (err > 0 && acc > amax - err) acc = amax;
      else if (err < 0 && acc < amin - err) acc = amin;
      else acc = acc + err;
      err_sum[i] = acc;
      diff = err - prev_err[i];
      prev_err[i] = err;
      kp = (i < 2) ? kp_xy_cfg : kp_z_cfg;
      t = gain_term(err, kp) + gain_term(acc, ki_cfg) + gain_term(diff, kd_cfg);
      vw[i] = (t < VW_LO) ? VW_LO : ((t > VW_HI) ? VW_HI : t);
      if (err >= 64'sd16777216 || err <= -64'sd16777216) far = 1'b1;
      else dist_sq += longint'(err * err);
    end
    for (int j = 0; j < 3; j++) begin
      s = 0;
      for (int i = 0; i < 3; i++) s += longint'(rot[i * 3 + j]) * vw[i];
      q = (s + 8192) >>> 14;
      if (q > VEL_HI) q = VEL_HI;
      if (q < VEL_LO) q = VEL_LO;
      out_vel[j] = q[31:0];
    end
    cmd.vel_x = out_vel[0];
    cmd.vel_y = out_vel[1];
    cmd.vel_z = out_vel[2];
    cmd.at_goal = !far && (dist_sq < (longint'(reach_sq_cfg) << 16));
    return cmd;
  endfunction

  function automatic pose_t pose_at(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                    logic [POS_W-1:0] pz, logic [ROT_W-1:0] diag,
                                    logic [ROT_W-1:0] off);
    pose_t p;
    p.pos_x = px;
    p.pos_y = py;
    p.pos_z = pz;
    {p.rot_00, p.rot_01, p.rot_02, p.rot_10, p.rot_11, p.rot_12,
     p.rot_20, p.rot_21, p.rot_22} = {diag, off, off, off, diag, off, off, off, diag};
    return p;
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    logic signed [POS_W-1:0] pos [3];
    logic signed [POS_W-1:0] off;
    logic signed [ROT_W-1:0] r [9];
    int col [3];
    int unsigned pick;
    int unsigned scale;
    pick = $urandom_range(99);
    scale = $urandom_range(16);
    for (int i = 0; i < 3; i++) begin
      if (pick < 50) begin
        off = $urandom_range((1 << scale) - 1);
        if ($urandom_range(1)) off = -off;
        pos[i] = goal_cfg[i] - off;
      end else begin
        case ($urandom_range(3))
          0: begin
            off = FAR_EDGE - 2 + $urandom_range(3);
            if ($urandom_range(1)) off = -off;
            pos[i] = goal_cfg[i] - off;
          end
          1: pos[i] = $urandom;
          2: begin
            off = $urandom_range(65535);
            if ($urandom_range(1)) off = -off;
            pos[i] = goal_cfg[i] - off;
          end
          default: begin
            case ($urandom_range(3))
              0: pos[i] = POS_MAX;
              1: pos[i] = POS_MIN;
              2: pos[i] = '0;
              default: pos[i] = goal_cfg[i];
            endcase
          end
        endcase
      end
    end
    pick = $urandom_range(99);
    if (pick < 60) begin
      col[0] = $urandom_range(2);
      col[1] = (col[0] + 1 + $urandom_range(1)) % 3;
      col[2] = 3 - col[0] - col[1];
      for (int k = 0; k < 9; k++) r[k] = '0;
      for (int i = 0; i < 3; i++) r[i * 3 + col[i]] = $urandom_range(1) ? UNIT : -UNIT;
    end else if (pick < 85) begin
      for (int k = 0; k < 9; k++) r[k] = 16'($urandom_range(32768) - 16384);
    end else begin
      for (int k = 0; k < 9; k++) r[k] = 16'($urandom);
    end
    p.pos_x = pos[0];
    p.pos_y = pos[1];
    p.pos_z = pos[2];
    {p.rot_00, p.rot_01, p.rot_02, p.rot_10, p.rot_11, p.rot_12,
     p.rot_20, p.rot_21, p.rot_22} = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]};
    return p;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_GOAL_X:         goal_cfg[0] = data;
      REG_GOAL_Y:         goal_cfg[1] = data;
      REG_GOAL_Z:         goal_cfg[2] = data;
      REG_KP_XY:          kp_xy_cfg = data[GAIN_W-1:0];
      REG_KP_Z:           kp_z_cfg = data[GAIN_W-1:0];
      REG_KI_ALL:         ki_cfg = data[GAIN_W-1:0];
      REG_KD_ALL:         kd_cfg = data[GAIN_W-1:0];
      REG_REACH_LIMIT_SQ: reach_sq_cfg = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                logic [15:0] kpxy, logic [15:0] kpz, logic [15:0] kint,
                                logic [15:0] kder, logic [31:0] reach);
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_GOAL_Z, gz);
    write_reg(REG_KP_XY, {16'($urandom), kpxy});
    write_reg(REG_KP_Z, {16'($urandom), kpz});
    write_reg(REG_KI_ALL, {16'($urandom), kint});
    write_reg(REG_KD_ALL, {16'($urandom), kder});
    write_reg(REG_REACH_LIMIT_SQ, reach);
    cfg.valid <= 1'b0;
    settings_count++;
  endtask

  task automatic wait_for_results();
    while (pending_poses.size() != 0 || pose.valid || expected_cmds.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pose.valid <= 1'b0;
    end else begin
      if (pose.valid && pose.ready) begin
        expected_cmds.push_back(predict_velocity_command(sent_pose));
        poses_taken++;
      end
      if (!pose.valid || pose.ready) begin
        if (pending_poses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sent_pose = pending_poses.pop_front();
          pose.valid  <= 1'b1;
          pose.pos_x  <= sent_pose.pos_x;
          pose.pos_y  <= sent_pose.pos_y;
          pose.pos_z  <= sent_pose.pos_z;
          pose.rot_00 <= sent_pose.rot_00;
          pose.rot_01 <= sent_pose.rot_01;
          pose.rot_02 <= sent_pose.rot_02;
          pose.rot_10 <= sent_pose.rot_10;
          pose.rot_11 <= sent_pose.rot_11;
          pose.rot_12 <= sent_pose.rot_12;
          pose.rot_20 <= sent_pose.rot_20;
          pose.rot_21 <= sent_pose.rot_21;
          pose.rot_22 <= sent_pose.rot_22;
        end else begin
          pose.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    vel_t want;
    if (rst) begin
      vel.ready <= 1'b0;
    end else begin
      if (vel.valid && vel.ready) begin
        results_seen++;
        if (vel.at_goal) reached_count++;
        if (expected_cmds.size() == 0) begin
          $display("%0t unexpected result: vel %0d %0d %0d reached %0b", $time,
                   vel.vel_x, vel.vel_y, vel.vel_z, vel.at_goal);
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          if (vel.vel_x !== want.vel_x) begin
            $display("%0t vel_x: expected %0d, got %0d", $time, want.vel_x, vel.vel_x);
            mismatches++;
          end
          if (vel.vel_y !== want.vel_y) begin
            $display("%0t vel_y: expected %0d, got %0d", $time, want.vel_y, vel.vel_y);
            mismatches++;
          end
          if (vel.vel_z !== want.vel_z) begin
            $display("%0t vel_z: expected %0d, got %0d", $time, want.vel_z, vel.vel_z);
            mismatches++;
          end
          if (vel.at_goal !== want.at_goal) begin
            $display("%0t at_goal: expected %0b, got %0b", $time,
                     want.at_goal, vel.at_goal);
            mismatches++;
          end
        end
      end
      vel.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    rst = 1'b1;
    pose.valid = 1'b0;
    pose.pos_x = '0;
    pose.pos_y = '0;
    pose.pos_z = '0;
    pose.rot_00 = '0;
    pose.rot_01 = '0;
    pose.rot_02 = '0;
    pose.rot_10 = '0;
    pose.rot_11 = '0;
    pose.rot_12 = '0;
    pose.rot_20 = '0;
    pose.rot_21 = '0;
    pose.rot_22 = '0;
    vel.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_GOAL_X;
    cfg.data = '0;
    send_idle_pct = 31;
    recv_stall_pct = 50;
    poses_taken = 0;
    results_seen = 0;
    reached_count = 0;
    settings_count = 0;
    mismatches = 0;
    goal_cfg[0] = 32'sd0;
    goal_cfg[1] = 32'sd0;
    goal_cfg[2] = 32'sd98304;
    kp_xy_cfg = 16'd410;
    kp_z_cfg = 16'd1229;
    ki_cfg = 16'd0;
    kd_cfg = 16'd2048;
    reach_sq_cfg = 32'd655;
    for (int i = 0; i < 3; i++) begin
      err_sum[i] = 0;
      prev_err[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    pending_poses.push_back(pose_at(goal_cfg[0], goal_cfg[1], goal_cfg[2], UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0] - 6551, goal_cfg[1], goal_cfg[2], UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0] - 6552, goal_cfg[1], goal_cfg[2], UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0], goal_cfg[1] + 6551, goal_cfg[2], UNIT, UNIT));
    pending_poses.push_back(pose_at(POS_MAX, POS_MAX, POS_MAX, UNIT, UNIT));
    pending_poses.push_back(pose_at(POS_MIN, POS_MIN, POS_MIN, -UNIT, -UNIT));
    pending_poses.push_back(pose_at(POS_MAX, POS_MAX, POS_MAX, ROT_CODE_MIN, ROT_CODE_MIN));
    pending_poses.push_back(pose_at(POS_MIN, POS_MIN, POS_MIN, ROT_CODE_MAX, ROT_CODE_MAX));
    pending_poses.push_back(pose_at(goal_cfg[0] - (FAR_EDGE - 1), goal_cfg[1], goal_cfg[2],
                                    UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0] - FAR_EDGE, goal_cfg[1], goal_cfg[2],
                                    UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0], goal_cfg[1] + (FAR_EDGE - 1), goal_cfg[2],
                                    UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0], goal_cfg[1], goal_cfg[2] + FAR_EDGE,
                                    UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0] - 100, goal_cfg[1] + 200, goal_cfg[2] - 300,
                                    16'sh2000, 16'shE000));
    pending_poses.push_back(pose_at('0, '0, '0, '0, '0));
    pending_poses.push_back(pose_at(goal_cfg[0] + 1, goal_cfg[1] - 1, goal_cfg[2] + 1,
                                    '0, UNIT));
    wait_for_results();

    apply_settings(32'($urandom_range(1048576)) - 32'd524288,
                   32'($urandom_range(1048576)) - 32'd524288,
                   32'($urandom_range(1048576)) - 32'd524288,
                   16'hFFFF, 16'h0000, 16'd4096, 16'hFFFF, 32'd16384);
    pending_poses.push_back(pose_at(goal_cfg[0] - 32768, goal_cfg[1], goal_cfg[2], UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0] - 32767, goal_cfg[1], goal_cfg[2], UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0], goal_cfg[1], goal_cfg[2] + 32768, UNIT, '0));
    pending_poses.push_back(pose_at(goal_cfg[0] - 23170, goal_cfg[1] - 23170, goal_cfg[2],
                                    UNIT, '0));
    pending_poses.push_back(pose_at(POS_MAX, POS_MAX, POS_MAX, UNIT, -UNIT));
    pending_poses.push_back(pose_at(POS_MIN, POS_MIN, POS_MIN, -UNIT, UNIT));
    repeat (300) pending_poses.push_back(random_pose());
    wait_for_results();

    send_idle_pct <= 50;
    recv_stall_pct <= 31;
    apply_settings(POS_MAX, POS_MAX, POS_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   32'hFFFFFFFF);
    repeat (300) pending_poses.push_back(random_pose());
    wait_for_results();

    apply_settings(POS_MIN, POS_MIN, POS_MIN, '0, '0, '0, '0, '0);
    repeat (250) pending_poses.push_back(random_pose());
    wait_for_results();

    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    apply_settings($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), $urandom);
    repeat (300) pending_poses.push_back(random_pose());
    wait_for_results();

    apply_settings(32'($urandom_range(2097152)) - 32'd1048576,
                   32'($urandom_range(2097152)) - 32'd1048576,
                   32'($urandom_range(2097152)) - 32'd1048576,
                   16'($urandom_range(8191)), 16'($urandom_range(8191)),
                   16'($urandom_range(63)), 16'($urandom_range(4095)),
                   32'($urandom_range(65535)));
    repeat (500) pending_poses.push_back(random_pose());
    wait_for_results();

    repeat (50) @(posedge clk);
    $display("covered %0d pose requests and %0d velocity results over %0d register settings",
             poses_taken, results_seen, settings_count);
    $display("goal reached on %0d results, %0d mismatches", reached_count, mismatches);
    if (mismatches == 0) begin
      $display("three_axis_pid_velocity_command_tb OK");
    end else begin
      $display("three_axis_pid_velocity_command_tb NOT OK");
    end
    $finish;
  end

endmodule
